### hw/rtl/cqw_pkg.sv
// Shared types and constants for the circular queue with walk.
`default_nettype none

package cqw_pkg;

  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 4;

  typedef logic [1:0] op_t;

  localparam op_t OP_PUSH  = 2'd0;
  localparam op_t OP_POP   = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;
  localparam op_t OP_WALK  = 2'd3;

  // One decoded request as it waits between the front and the back.
  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/cqw_if.sv
// Request and result channel interfaces of the circular queue with walk.
`default_nettype none

interface cqw_in_if;
  logic                         valid;
  logic                         ready;
  cqw_pkg::op_t                 op;
  logic [cqw_pkg::VALUE_W-1:0]  push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface cqw_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [cqw_pkg::VALUE_W-1:0]  item_value;
  logic [cqw_pkg::SLOT_W-1:0]   item_slot;
  logic                         last_item;
  logic [cqw_pkg::VALUE_W-1:0]  head_value;
  logic [cqw_pkg::SLOT_W-1:0]   entry_count;
  logic                         is_empty;
  logic                         is_full;

  modport source (output valid, output ok, output item_value, output item_slot,
                  output last_item, output head_value, output entry_count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input item_value, input item_slot,
                  input last_item, input head_value, input entry_count,
                  input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

### hw/rtl/cqw_front.sv
// Request front end: decodes incoming requests into a two-entry command queue.
`default_nettype none

module cqw_front #(
  parameter int WORD_BITS = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  cqw_in_if.sink       in_if,
  output cqw_pkg::cmd_t cmd,
  output logic         cmd_valid,
  input  wire logic    cmd_ready
);

  localparam int VW = cqw_pkg::VALUE_W;
  localparam int W  = (WORD_BITS < VW) ? WORD_BITS : VW;
  localparam int QD = 2;

  cqw_pkg::cmd_t q_r [QD];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;
  cqw_pkg::cmd_t dec;

  assign in_if.ready = (cnt_r != 2'(QD));
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rd_ptr_r];

  assign push = in_if.valid && in_if.ready;
  assign pop  = cmd_valid && cmd_ready;

  // The data word is trimmed to the storage width here so the back never sees
  // bits that the ring cannot hold.
  always_comb begin
    dec.op    = in_if.op;
    dec.value = VW'(in_if.push_value[W-1:0]);
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cqw_back.sv
// Execution back end: ring indices, slot storage, walk sequencer and result register.
`default_nettype none

module cqw_back #(
  parameter int RING_SLOTS = 16,
  parameter int WORD_BITS  = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cqw_pkg::cmd_t cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  cqw_out_if.source          out_if
);

  localparam int VW = cqw_pkg::VALUE_W;
  localparam int SW = cqw_pkg::SLOT_W;
  localparam int W  = (WORD_BITS < VW) ? WORD_BITS : VW;
  localparam int IW = $clog2(RING_SLOTS);
  localparam int CW = IW + 1;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    logic [IW-1:0] n;
    if (i == IW'(RING_SLOTS - 1)) begin
      n = '0;
    end else begin
      n = i + 1'b1;
    end
    return n;
  endfunction

  logic [W-1:0]  mem_r [RING_SLOTS];
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] walk_r, walk_nxt;
  logic          walking_r, walking_nxt;

  logic          out_valid_r;
  logic          ok_r, ok_nxt;
  logic          last_r, last_nxt;
  logic          item_sel_r, item_sel_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] count_r, count_nxt;
  logic          empty_r, empty_nxt;
  logic          full_r, full_nxt;
  logic [W-1:0]  head_word_r;
  logic [W-1:0]  item_word_r;

  logic          advance;
  logic          is_empty, is_full;
  logic [IW-1:0] tail_inc;
  logic [IW-1:0] pos, pos_inc;
  logic          we;
  logic [W-1:0]  wdata;
  logic [CW-1:0] cnt_w;

  assign advance   = cmd_valid && (!out_valid_r || out_if.ready);
  assign is_empty  = (head_r == tail_r);
  assign tail_inc  = ring_next(tail_r);
  assign is_full   = (tail_inc == head_r);
  assign pos       = walking_r ? walk_r : head_r;
  assign pos_inc   = ring_next(pos);
  assign wdata     = cmd.value[W-1:0];

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    walk_nxt     = walk_r;
    walking_nxt  = walking_r;
    we           = 1'b0;
    ok_nxt       = 1'b1;
    last_nxt     = 1'b1;
    item_sel_nxt = 1'b0;
    slot_nxt     = '0;
    cmd_ready    = advance;
    unique case (cmd.op)
      cqw_pkg::OP_PUSH: begin
        ok_nxt = !is_full;
        if (!is_full) begin
          we       = 1'b1;
          tail_nxt = tail_inc;
        end
      end
      cqw_pkg::OP_POP: begin
        ok_nxt = !is_empty;
        if (!is_empty) begin
          head_nxt = ring_next(head_r);
        end
      end
      cqw_pkg::OP_CLEAR: begin
        head_nxt = tail_r;
      end
      cqw_pkg::OP_WALK: begin
        if (is_empty) begin
          ok_nxt = 1'b0;
        end else begin
          // One stored word per cycle while the output is not stalled; the command stays queued until the last one.
          item_sel_nxt = 1'b1;
          slot_nxt     = SW'(pos);
          last_nxt     = (pos_inc == tail_r);
          walk_nxt     = pos_inc;
          walking_nxt  = !last_nxt;
          cmd_ready    = advance && last_nxt;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (tail_nxt >= head_nxt) begin
      cnt_w = CW'(tail_nxt) - CW'(head_nxt);
    end else begin
      cnt_w = CW'(tail_nxt) + CW'(RING_SLOTS) - CW'(head_nxt);
    end
    count_nxt = SW'(cnt_w);
    empty_nxt = (head_nxt == tail_nxt);
    full_nxt  = (ring_next(tail_nxt) == head_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      walk_r      <= '0;
      walking_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        walk_r    <= walk_nxt;
        walking_r <= walking_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot storage with registered reads. A push into an empty ring writes the
  // slot that becomes the head, so that word is forwarded into the head read.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (we) begin
        mem_r[tail_r] <= wdata;
      end
      if (we && (tail_r == head_nxt)) begin
        head_word_r <= wdata;
      end else begin
        head_word_r <= mem_r[head_nxt];
      end
      item_word_r <= mem_r[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ok_r       <= ok_nxt;
      last_r     <= last_nxt;
      item_sel_r <= item_sel_nxt;
      slot_r     <= slot_nxt;
      count_r    <= count_nxt;
      empty_r    <= empty_nxt;
      full_r     <= full_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.ok          = ok_r;
  assign out_if.item_value  = item_sel_r ? VW'(item_word_r) : '0;
  assign out_if.item_slot   = slot_r;
  assign out_if.last_item   = last_r;
  assign out_if.head_value  = empty_r ? '0 : VW'(head_word_r);
  assign out_if.entry_count = count_r;
  assign out_if.is_empty    = empty_r;
  assign out_if.is_full     = full_r;

endmodule

`default_nettype wire

### hw/rtl/circular_queue_with_walk.sv
// Top level of the circular queue with walk: front end, back end and checks.
`default_nettype none

// A ring-buffer queue of RING_SLOTS slots that holds up to RING_SLOTS-1 words.
// Push, pop and clear each give one result and run at one transaction per
// cycle unless the output stalls; a request passes through the command queue
// and then the registered execution stage before its result appears on the
// output channel. A walk gives one result per stored word, in order from the
// head, and occupies the execution stage until its last word, since the slot
// storage delivers one walked word per cycle unless the output stalls; a walk
// of an empty queue gives a single failed result. A two-entry command queue
// between the request channel and the execution stage still takes requests
// while a walk runs or a result waits. There is no clearing pass after reset.
module circular_queue_with_walk #(
  parameter int RING_SLOTS = 16,
  parameter int WORD_BITS  = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cqw_in_if.sink    in_if,
  cqw_out_if.source out_if
);

  localparam int SW = cqw_pkg::SLOT_W;

  cqw_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_ready;

  cqw_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  cqw_back #(
    .RING_SLOTS (RING_SLOTS),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .out_if    (out_if)
  );

  a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !(out_if.is_empty && out_if.is_full))
    else $error("result reports empty and full together");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.is_empty |-> out_if.entry_count == '0 &&
                                        out_if.head_value == '0)
    else $error("empty queue reports stored words");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.is_full |-> out_if.entry_count == SW'(RING_SLOTS - 1))
    else $error("full queue reports a wrong count");

  a_mid_walk_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.last_item |-> out_if.ok && !out_if.is_empty)
    else $error("non-final result outside a successful walk");

  a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("queued command lost before the back end took it");

endmodule

`default_nettype wire

### test/cqw_result_checker.sv
// Checker for the circular queue with walk: predicts each reply and compares it.
module cqw_result_checker
  import cqw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  op_t                in_op,
  input  logic [VALUE_W-1:0] in_push_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_ok,
  input  logic [VALUE_W-1:0] out_item_value,
  input  logic [SLOT_W-1:0]  out_item_slot,
  input  logic               out_last_item,
  input  logic [VALUE_W-1:0] out_head_value,
  input  logic [SLOT_W-1:0]  out_entry_count,
  input  logic               out_is_empty,
  input  logic               out_is_full,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] item_value;
    logic [SLOT_W-1:0]  item_slot;
    logic               last_item;
    logic [VALUE_W-1:0] head_value;
    logic [SLOT_W-1:0]  entry_count;
    logic               is_empty;
    logic               is_full;
  } reply_t;

  // With sixteen slots the ring indices wrap naturally at the slot index width.
  logic [VALUE_W-1:0] ring [16];
  logic [SLOT_W-1:0]  head_ix;
  logic [SLOT_W-1:0]  tail_ix;
  reply_t             predicted_replies [$];

  function automatic reply_t ring_status(logic ok, logic [VALUE_W-1:0] item,
                                         logic [SLOT_W-1:0] slot, logic last);
    reply_t             r;
    logic [SLOT_W-1:0]  after_tail;
    after_tail    = tail_ix + 1'b1;
    r.ok          = ok;
    r.item_value  = item;
    r.item_slot   = slot;
    r.last_item   = last;
    r.is_empty    = (head_ix == tail_ix);
    r.is_full     = (after_tail == head_ix);
    r.entry_count = tail_ix - head_ix;
    r.head_value  = r.is_empty ? '0 : ring[head_ix];
    return r;
  endfunction

  task automatic apply_request(op_t op, logic [VALUE_W-1:0] value);
    logic [SLOT_W-1:0] pos;
    logic [SLOT_W-1:0] nxt;
    case (op)
      OP_PUSH: begin
        nxt = tail_ix + 1'b1;
        if (nxt == head_ix) begin
          predicted_replies.push_back(ring_status(1'b0, '0, '0, 1'b1));
        end else begin
          ring[tail_ix] = value;
          tail_ix = nxt;
          predicted_replies.push_back(ring_status(1'b1, '0, '0, 1'b1));
        end
      end
      OP_POP: begin
        if (head_ix == tail_ix) begin
          predicted_replies.push_back(ring_status(1'b0, '0, '0, 1'b1));
        end else begin
          head_ix = head_ix + 1'b1;
          predicted_replies.push_back(ring_status(1'b1, '0, '0, 1'b1));
        end
      end
      OP_CLEAR: begin
        head_ix = tail_ix;
        predicted_replies.push_back(ring_status(1'b1, '0, '0, 1'b1));
      end
      OP_WALK: begin
        if (head_ix == tail_ix) begin
          predicted_replies.push_back(ring_status(1'b0, '0, '0, 1'b1));
        end else begin
          pos = head_ix;
          while (pos != tail_ix) begin
            nxt = pos + 1'b1;
            predicted_replies.push_back(ring_status(1'b1, ring[pos], pos, nxt == tail_ix));
            pos = nxt;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      head_ix = '0;
      tail_ix = '0;
      predicted_replies.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      // A reply can never belong to a request taken at the same edge.
      if (out_valid && out_ready) begin
        got = '{out_ok, out_item_value, out_item_slot, out_last_item, out_head_value,
                out_entry_count, out_is_empty, out_is_full};
        if (predicted_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected reply: ok=%0b item=%h slot=%0d last=%0b head=%h count=%0d",
                     got.ok, got.item_value, got.item_slot, got.last_item,
                     got.head_value, got.entry_count);
        end else begin
          want = predicted_replies.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("reply mismatch: expected ok=%0b item=%h slot=%0d last=%0b head=%h %s",
                       want.ok, want.item_value, want.item_slot, want.last_item,
                       want.head_value, $sformatf("count=%0d empty=%0b full=%0b",
                       want.entry_count, want.is_empty, want.is_full));
              $display("                got      ok=%0b item=%h slot=%0d last=%0b head=%h %s",
                       got.ok, got.item_value, got.item_slot, got.last_item,
                       got.head_value, $sformatf("count=%0d empty=%0b full=%0b",
                       got.entry_count, got.is_empty, got.is_full));
            end
          end
        end
      end
      if (in_valid && in_ready) apply_request(in_op, in_push_value);
      outstanding <= predicted_replies.size();
    end
  end

endmodule

### test/circular_queue_with_walk_tb.sv
// Testbench top for the circular queue with walk: stimulus, stalls and verdict.
module circular_queue_with_walk_tb;
  import cqw_pkg::*;

  localparam int TIMEOUT_CYCLES  = 300000;
  localparam int RANDOM_REQUESTS = 460;

  logic clk;
  logic rst_n;
  logic steady;
  int   cycle_count = 0;
  int   mismatches;
  int   outstanding;

  cqw_in_if  in_ch ();
  cqw_out_if out_ch ();

  circular_queue_with_walk u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  cqw_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_op           (in_ch.op),
    .in_push_value   (in_ch.push_value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_ok          (out_ch.ok),
    .out_item_value  (out_ch.item_value),
    .out_item_slot   (out_ch.item_slot),
    .out_last_item   (out_ch.last_item),
    .out_head_value  (out_ch.head_value),
    .out_entry_count (out_ch.entry_count),
    .out_is_empty    (out_ch.is_empty),
    .out_is_full     (out_ch.is_full),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The result side stalls about a quarter of the time outside the steady stretch.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // Leaves valid high after the transaction so back-to-back requests stay possible.
  task automatic send_request(op_t op, logic [VALUE_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.push_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    int  roll;
    int  push_share;
    op_t op;
    push_share       = 42;
    rst_n            <= 1'b0;
    steady           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_PUSH;
    in_ch.push_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Refused walk and pop and a clear on an empty queue, then the value extremes.
    send_request(OP_WALK, '0);
    send_request(OP_POP, '1);
    send_request(OP_CLEAR, '0);
    send_request(OP_PUSH, '0);
    send_request(OP_PUSH, '1);
    send_request(OP_WALK, $urandom);
    send_request(OP_POP, '0);
    send_request(OP_WALK, '0);
    // Fill to capacity, try one push too many, walk the full ring and clear it.
    for (int i = 0; i < 14; i++) send_request(OP_PUSH, $urandom);
    send_request(OP_PUSH, 32'hA5A5_5A5A);
    send_request(OP_WALK, '0);
    send_request(OP_CLEAR, '0);
    send_request(OP_WALK, '0);

    // Phases that lean toward filling, draining or neither keep the ring
    // moving between empty and full and wrapping its indices.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_share = 62;
          1:       push_share = 22;
          default: push_share = 42;
        endcase
      end
      steady <= (i >= 180 && i < 280);
      roll = $urandom_range(0, 99);
      if (roll < 3)                    op = OP_CLEAR;
      else if (roll < 13)              op = OP_WALK;
      else if (roll < 13 + push_share) op = OP_PUSH;
      else                             op = OP_POP;
      send_request(op, $urandom);
    end
    in_ch.valid <= 1'b0;
    steady      <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cqw_pkg.sv
hw/rtl/cqw_if.sv
hw/rtl/cqw_front.sv
hw/rtl/cqw_back.sv
hw/rtl/circular_queue_with_walk.sv
test/cqw_result_checker.sv
test/circular_queue_with_walk_tb.sv
